// ===== hw/rtl/pps_pkg.sv =====
// Package: shared constants, codes and item types of the priority scheduler.
`timescale 1ns / 1ps

package pps_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int TIME_BITS = 16;

    localparam int SLOT_W  = $clog2(MAX_SLOTS);
    localparam int COUNT_W = $clog2(MAX_SLOTS + 1);
    localparam int CFG_W   = 5;
    localparam int PRIO_W  = 8;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam int PROCESS_COUNT_RESET = 16;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic                 kind;
        logic [3:0]           slot;
        logic [15:0]          arrival_time;
        logic [15:0]          burst_length;
        logic [7:0]           priority_level;
    } in_item_t;

    typedef struct packed {
        logic                 ran;
        logic [3:0]           run_slot;
        logic                 finished;
        logic [15:0]          finish_time;
        logic [15:0]          turnaround;
        logic [15:0]          waiting;
        logic                 all_done;
    } out_item_t;

    // One slot of the process table as held in memory.
    typedef struct packed {
        logic [TIME_BITS-1:0] arrival;
        logic [TIME_BITS-1:0] burst;
        logic [PRIO_W-1:0]    prio;
        logic [TIME_BITS-1:0] remaining;
    } entry_t;

    // Result handshake between the core and the output register.
    typedef struct packed {
        logic      valid;
        out_item_t data;
    } result_req_t;

endpackage

// ===== hw/rtl/pps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/pps_core.sv =====
// Scheduler core: slot table memory, scan sequencer and tick update.
`timescale 1ns / 1ps

module pps_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pps_pkg::CFG_W-1:0]   process_count,
    input  logic                        item_valid,
    input  pps_pkg::in_item_t           item,
    output logic                        ready,
    output pps_pkg::result_req_t        res,
    input  logic                        res_take
);

    localparam int SW = pps_pkg::SLOT_W;
    localparam int CW = pps_pkg::COUNT_W;
    localparam int TW = pps_pkg::TIME_BITS;
    localparam int N  = pps_pkg::MAX_SLOTS;

    pps_pkg::state_t    state_reg, state_next;
    logic [TW-1:0]      time_reg, time_next;
    logic [N-1:0]       written_reg, written_next;
    logic [N-1:0]       done_reg, done_next;
    logic [CW-1:0]      scan_idx_reg, scan_idx_next;
    logic               eval_valid_reg, eval_valid_next;
    logic [SW-1:0]      eval_idx_reg, eval_idx_next;
    logic               found_reg, found_next;
    logic [SW-1:0]      pick_reg, pick_next;
    pps_pkg::entry_t    best_reg, best_next;
    pps_pkg::out_item_t res_reg, res_next;

    logic [CW-1:0]      count_eff;
    logic               issue;
    logic               accept;
    logic               load_ok;
    pps_pkg::entry_t    rd_entry;
    logic               eligible;
    logic               better;
    logic [TW-1:0]      time_inc;
    logic [TW-1:0]      rem_dec;
    logic               fin;
    logic [TW-1:0]      tat;
    logic [TW-1:0]      wait_amt;
    logic               all_done;

    logic                          ram_we;
    logic [SW-1:0]                 ram_waddr;
    pps_pkg::entry_t               ram_wdata;
    logic [$bits(pps_pkg::entry_t)-1:0] ram_rdata;

    pps_ram #(
        .WIDTH ($bits(pps_pkg::entry_t)),
        .DEPTH (N)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (scan_idx_reg[SW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_entry  = pps_pkg::entry_t'(ram_rdata);
    assign count_eff = (32'(process_count) > N) ? CW'(N) : CW'(process_count);
    assign ready     = (state_reg == pps_pkg::ST_IDLE);
    assign accept    = ready && item_valid;
    assign load_ok   = accept && (item.kind == pps_pkg::KIND_LOAD) && (32'(item.slot) < N);
    assign issue     = (state_reg == pps_pkg::ST_SCAN) && (scan_idx_reg < count_eff);

    // Candidate check on the entry read back last cycle.
    assign eligible = eval_valid_reg && written_reg[eval_idx_reg] && !done_reg[eval_idx_reg]
                      && (rd_entry.remaining != '0) && (rd_entry.arrival <= time_reg);
    assign better   = eligible && (!found_reg || (rd_entry.prio < best_reg.prio));

    assign time_inc = (time_reg == pps_pkg::TIME_MAX) ? time_reg : time_reg + TW'(1);
    assign rem_dec  = best_reg.remaining - TW'(1);
    assign fin      = found_reg && (rem_dec == '0);
    assign tat      = (time_inc > best_reg.arrival) ? time_inc - best_reg.arrival : '0;
    assign wait_amt = (tat > best_reg.burst) ? tat - best_reg.burst : '0;

    always_comb
    begin
        all_done = 1'b1;
        for (int i = 0; i < N; i++)
        begin
            if ((i < int'(count_eff)) && !done_reg[i])
            begin
                all_done = 1'b0;
            end
        end
    end

    // Table write: a load fills a slot, a tick writes back the remaining burst.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = item.slot[SW-1:0];
        ram_wdata = '{arrival:   item.arrival_time[TW-1:0],
                      burst:     item.burst_length[TW-1:0],
                      prio:      item.priority_level,
                      remaining: item.burst_length[TW-1:0]};
        if (load_ok)
        begin
            ram_we = 1'b1;
        end
        else if ((state_reg == pps_pkg::ST_UPDATE) && found_reg)
        begin
            ram_we              = 1'b1;
            ram_waddr           = pick_reg;
            ram_wdata           = best_reg;
            ram_wdata.remaining = rem_dec;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        time_next       = time_reg;
        written_next    = written_reg;
        done_next       = done_reg;
        scan_idx_next   = scan_idx_reg;
        eval_valid_next = issue;
        eval_idx_next   = scan_idx_reg[SW-1:0];
        found_next      = found_reg;
        pick_next       = pick_reg;
        best_next       = best_reg;
        res_next        = res_reg;

        case (state_reg)
            pps_pkg::ST_IDLE:
            begin
                if (load_ok)
                begin
                    written_next[item.slot[SW-1:0]] = 1'b1;
                    done_next[item.slot[SW-1:0]]    = 1'b0;
                end
                if (accept && (item.kind == pps_pkg::KIND_TICK))
                begin
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    state_next    = pps_pkg::ST_SCAN;
                end
            end
            pps_pkg::ST_SCAN:
            begin
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                else
                begin
                    state_next = pps_pkg::ST_UPDATE;
                end
                if (better)
                begin
                    found_next = 1'b1;
                    pick_next  = eval_idx_reg;
                    best_next  = rd_entry;
                end
            end
            pps_pkg::ST_UPDATE:
            begin
                time_next            = time_inc;
                res_next.ran         = found_reg;
                res_next.run_slot    = found_reg ? 4'(pick_reg) : 4'd0;
                res_next.finished    = fin;
                res_next.finish_time = 16'(time_inc);
                res_next.turnaround  = fin ? 16'(tat) : 16'd0;
                res_next.waiting     = fin ? 16'(wait_amt) : 16'd0;
                res_next.all_done    = 1'b0;
                if (fin)
                begin
                    done_next[pick_reg] = 1'b1;
                end
                state_next = pps_pkg::ST_PUSH;
            end
            pps_pkg::ST_PUSH:
            begin
                if (res_take)
                begin
                    state_next = pps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pps_pkg::ST_IDLE;
            time_reg       <= '0;
            written_reg    <= '0;
            done_reg       <= '0;
            scan_idx_reg   <= '0;
            eval_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            time_reg       <= time_next;
            written_reg    <= written_next;
            done_reg       <= done_next;
            scan_idx_reg   <= scan_idx_next;
            eval_valid_reg <= eval_valid_next;
            found_reg      <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg <= eval_idx_next;
        pick_reg     <= pick_next;
        best_reg     <= best_next;
        res_reg      <= res_next;
    end

    // All-done reflects the done marks after this tick's update.
    always_comb
    begin
        res.valid         = (state_reg == pps_pkg::ST_PUSH);
        res.data          = res_reg;
        res.data.all_done = all_done;
    end

endmodule

// ===== hw/rtl/preemptive_priority_scheduler.sv =====
// Top level: preemptive priority scheduler with config register and output register.
`timescale 1ns / 1ps
//
// Usage
//   item channel (item_valid / item_stall / item): one request per item. A load
//   request (kind = load) writes a slot's arrival, burst and priority and rearms
//   it and yields no result. A tick request scans the slots
//   in use, runs the best eligible one for one unit and yields exactly one result.
//   result channel (result_valid / result_stall / result): one request per tick.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): writes process_count; always
//   ready. Write it only while no tick is in flight.
// Sequence
//   A tick scans count = min(process_count, 16) slots, reading the slot table
//   memory one entry per cycle, then writes back the remaining burst of the
//   chosen slot and registers the result. No new request is accepted until
//   the core has handed that result to the output register.
// Reset
//   Time, written marks and done marks clear; the slot table memory keeps its contents; process_count returns to 16.
// Stall
//   A stalled result holds in the output register; the core finishes the next
//   tick and waits to hand it over while the register stays full.
//
module preemptive_priority_scheduler (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  pps_pkg::in_item_t          item,
    output logic                       result_valid,
    input  logic                       result_stall,
    output pps_pkg::out_item_t         result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pps_pkg::CFG_W-1:0]  cfg_data
);

    logic [pps_pkg::CFG_W-1:0] process_count_reg;
    logic                      out_valid_reg, out_valid_next;
    pps_pkg::out_item_t        out_data_reg;
    logic                      core_ready;
    pps_pkg::result_req_t      core_res;
    logic                      res_take;

    // Configuration write: accept at any time, the block is idle by contract.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            process_count_reg <= pps_pkg::CFG_W'(pps_pkg::PROCESS_COUNT_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            process_count_reg <= cfg_data;
        end
    end

    pps_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .process_count (process_count_reg),
        .item_valid    (item_valid),
        .item          (item),
        .ready         (core_ready),
        .res           (core_res),
        .res_take      (res_take)
    );

    // Hold off new requests while the core is busy with a tick.
    assign item_stall = !core_ready;

    // Output register: take a new result when empty or when the current one leaves.
    assign res_take = !out_valid_reg || !result_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = core_res.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && core_res.valid)
        begin
            out_data_reg <= core_res.data;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

// ===== hw/rtl/pps_checker.sv =====
// Port-level checker for the priority scheduler and its bind.
`timescale 1ns / 1ps

module pps_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  logic                       item_stall,
    input  pps_pkg::in_item_t          item,
    input  logic                       result_valid,
    input  logic                       result_stall,
    input  pps_pkg::out_item_t         result,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [pps_pkg::CFG_W-1:0]  cfg_data
);

    // A stalled result holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // An accepted tick keeps the block busy in the following cycle.
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item.kind == pps_pkg::KIND_TICK) |=> item_stall)
        else $error("tick request accepted without busy period");

    // Completion only on a tick that ran a slot; idle ticks report slot zero.
    a_finish_ran: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.ran || (!result.finished && (result.run_slot == 4'd0))))
        else $error("idle tick reports a slot or a completion");

    // A load yields no result: the result register cannot fill right after one.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid && item_valid && !item_stall && (item.kind == pps_pkg::KIND_LOAD)
        |=> !result_valid)
        else $error("result appeared after a load request");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);
